>>> hdl/qmos_pkg.sv
// shared types and constants for the quad motor output selector
// no dependencies; imported by the control, lane and top modules

package qmos_pkg;

	localparam int MOTOR_COUNT = 4;

	localparam logic [10:0] W_MIN     = 11'd1000;
	localparam logic [10:0] W_MAX     = 11'd2000;
	localparam logic [10:0] DS_OFFSET = 11'd47;

	localparam logic [15:0] ARM_HOLD_RST    = 16'd3000;
	localparam logic [15:0] GRACE_RST       = 16'd150;
	localparam logic [9:0]  STICK_LIMIT_RST = 10'd350;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ARM_HOLD    = 2'd0;
	localparam cfg_idx_t CFG_GRACE       = 2'd1;
	localparam cfg_idx_t CFG_STICK_LIMIT = 2'd2;

	// per motor sign pattern of the x-frame mix: {neg_pitch, neg_roll, neg_yaw}
	localparam logic [2:0] MIX_SIGNS [MOTOR_COUNT] = '{3'b001, 3'b010, 3'b111, 3'b100};

	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_IDLE,
		MODE_DIRECT,
		MODE_MIX
	} mode_t;

	typedef struct packed {
		mode_t                         mode;
		logic                          send_valid;
		logic                          report_valid;
		logic                          from_pid;
		logic                          esc_is_armed;
		logic [MOTOR_COUNT-1:0][15:0]  direct;
		logic [10:0]                   thr;
		logic signed [10:0]            roll;
		logic signed [10:0]            pitch;
		logic signed [10:0]            yaw;
	} decision_t;

endpackage

>>> hdl/qmos_in_if.sv
// input channel of the motor output selector: one flight control update
// no dependencies

interface qmos_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        rc_armed;
	logic [15:0] rc_throttle;
	logic signed [15:0] rc_roll;
	logic signed [15:0] rc_pitch;
	logic signed [15:0] rc_yaw;
	logic        pid_fresh;
	logic [15:0] pid_front_left;
	logic [15:0] pid_front_right;
	logic [15:0] pid_rear_right;
	logic [15:0] pid_rear_left;

	modport source (
		output valid, now_ms, rc_armed, rc_throttle, rc_roll, rc_pitch, rc_yaw,
		       pid_fresh, pid_front_left, pid_front_right, pid_rear_right, pid_rear_left,
		input  ready
	);
	modport sink (
		input  valid, now_ms, rc_armed, rc_throttle, rc_roll, rc_pitch, rc_yaw,
		       pid_fresh, pid_front_left, pid_front_right, pid_rear_right, pid_rear_left,
		output ready
	);
endinterface

>>> hdl/qmos_out_if.sv
// output channel of the motor output selector: dshot frame and telemetry widths
// no dependencies

interface qmos_out_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [10:0] dshot_one;
	logic [10:0] dshot_two;
	logic [10:0] dshot_three;
	logic [10:0] dshot_four;
	logic        report_valid;
	logic [15:0] width_one;
	logic [15:0] width_two;
	logic [15:0] width_three;
	logic [15:0] width_four;
	logic        from_pid;
	logic        esc_is_armed;

	modport source (
		output valid, send_valid, dshot_one, dshot_two, dshot_three, dshot_four,
		       report_valid, width_one, width_two, width_three, width_four,
		       from_pid, esc_is_armed,
		input  ready
	);
	modport sink (
		input  valid, send_valid, dshot_one, dshot_two, dshot_three, dshot_four,
		       report_valid, width_one, width_two, width_three, width_four,
		       from_pid, esc_is_armed,
		output ready
	);
endinterface

>>> hdl/qmos_ctrl.sv
// arming, source selection and pid cache; registers the per-update decision
// depends on qmos_pkg

module qmos_ctrl
	import qmos_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               accept,
	input  logic [31:0]        now_ms,
	input  logic               rc_armed,
	input  logic [15:0]        rc_throttle,
	input  logic signed [15:0] rc_roll,
	input  logic signed [15:0] rc_pitch,
	input  logic signed [15:0] rc_yaw,
	input  logic               pid_fresh,
	input  logic [MOTOR_COUNT-1:0][15:0] pid_widths,
	output decision_t          dec_s1
);

	logic [15:0] arm_hold_q;
	logic [15:0] grace_q;
	logic [9:0]  stick_limit_q;

	logic        esc_armed_q;
	logic        arming_active_q;
	logic [31:0] arm_start_q;
	logic        source_pid_q;
	logic [31:0] lost_time_q;
	logic [MOTOR_COUNT-1:0][15:0] cache_q;

	logic        esc_armed_d;
	logic        arming_active_d;
	logic [31:0] arm_start_d;
	logic        source_pid_d;
	logic [31:0] lost_time_d;
	logic        cache_we;
	logic [31:0] arm_elapsed;
	logic [31:0] lost_elapsed;
	decision_t   dec;

	function automatic logic signed [10:0] clamp_stick(logic signed [15:0] v,
		logic [9:0] lim);
		logic signed [16:0] vx;
		logic signed [16:0] lx;
		begin
			vx = 17'(v);
			lx = signed'({7'b0, lim});
			if (vx > lx) begin
				clamp_stick = 11'(lx);
			end else if (vx < -lx) begin
				clamp_stick = 11'(-lx);
			end else begin
				clamp_stick = 11'(vx);
			end
		end
	endfunction

	always_comb begin
		esc_armed_d     = esc_armed_q;
		arming_active_d = arming_active_q;
		arm_start_d     = arm_start_q;
		source_pid_d    = source_pid_q;
		lost_time_d     = lost_time_q;
		cache_we        = 1'b0;
		arm_elapsed     = '0;
		lost_elapsed    = '0;

		dec.mode         = MODE_IDLE;
		dec.send_valid   = 1'b0;
		dec.report_valid = 1'b1;
		dec.direct       = pid_widths;
		dec.thr          = (rc_throttle < 16'(W_MIN)) ? W_MIN :
		                   (rc_throttle > 16'(W_MAX)) ? W_MAX : rc_throttle[10:0];
		dec.roll         = clamp_stick(rc_roll, stick_limit_q);
		dec.pitch        = clamp_stick(rc_pitch, stick_limit_q);
		dec.yaw          = clamp_stick(rc_yaw, stick_limit_q);

		if (!rc_armed) begin
			arming_active_d = 1'b0;
			dec.send_valid  = esc_armed_q;   // one zero frame to an armed esc
			esc_armed_d     = 1'b0;
		end else begin
			if (!esc_armed_q) begin
				if (!arming_active_q) begin
					arm_start_d = now_ms;
				end
				arm_elapsed = now_ms - arm_start_d;
				if (arm_elapsed < {16'b0, arm_hold_q}) begin
					arming_active_d = 1'b1;
					dec.mode        = MODE_ZERO;
					dec.report_valid = 1'b0;
				end else begin
					arming_active_d = 1'b0;
					esc_armed_d     = 1'b1;
				end
			end
			if (esc_armed_d) begin
				dec.send_valid = 1'b1;
				if (pid_fresh) begin
					cache_we     = 1'b1;
					source_pid_d = 1'b1;
					dec.mode     = MODE_DIRECT;
				end else begin
					if (source_pid_q) begin
						lost_time_d = now_ms;
					end
					source_pid_d = 1'b0;
					lost_elapsed = now_ms - lost_time_d;
					dec.direct   = cache_q;
					dec.mode     = (lost_elapsed < {16'b0, grace_q}) ? MODE_DIRECT : MODE_MIX;
				end
			end else begin
				dec.send_valid = 1'b1;
			end
		end
		dec.from_pid     = source_pid_d;
		dec.esc_is_armed = esc_armed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_hold_q      <= ARM_HOLD_RST;
			grace_q         <= GRACE_RST;
			stick_limit_q   <= STICK_LIMIT_RST;
			esc_armed_q     <= 1'b0;
			arming_active_q <= 1'b0;
			arm_start_q     <= '0;
			source_pid_q    <= 1'b1;
			lost_time_q     <= '0;
			cache_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ARM_HOLD:    arm_hold_q    <= cfg_data;
					CFG_GRACE:       grace_q       <= cfg_data;
					CFG_STICK_LIMIT: stick_limit_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (accept) begin
				esc_armed_q     <= esc_armed_d;
				arming_active_q <= arming_active_d;
				arm_start_q     <= arm_start_d;
				source_pid_q    <= source_pid_d;
				lost_time_q     <= lost_time_d;
				if (cache_we) begin
					cache_q <= pid_widths;
				end
			end
		end
	end

	// decision payload, qualified by the valid bit in the top level
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
	end

endmodule

>>> hdl/qmos_lane.sv
// one motor lane: x-frame stick mix, width selection and dshot mapping
// depends on qmos_pkg

module qmos_lane
	import qmos_pkg::*;
#(
	parameter logic [2:0] SIGNS = MIX_SIGNS[0]
)(
	input  decision_t   dec,
	input  logic [15:0] direct,
	output logic [15:0] width,
	output logic [10:0] dshot
);

	logic signed [13:0] t_x;
	logic signed [13:0] p_x;
	logic signed [13:0] r_x;
	logic signed [13:0] y_x;
	logic signed [13:0] mix_sum;
	logic [10:0]        mix_w;
	logic [10:0]        w_clamped;
	logic [9:0]         above_min;

	always_comb begin
		t_x = signed'({3'b0, dec.thr});
		p_x = SIGNS[2] ? -14'(dec.pitch) : 14'(dec.pitch);
		r_x = SIGNS[1] ? -14'(dec.roll)  : 14'(dec.roll);
		y_x = SIGNS[0] ? -14'(dec.yaw)   : 14'(dec.yaw);
		mix_sum = t_x + p_x + r_x + y_x;

		if (dec.thr == W_MIN) begin
			mix_w = W_MIN;   // throttle at idle cuts the mix
		end else if (mix_sum < signed'({3'b0, W_MIN})) begin
			mix_w = W_MIN;
		end else if (mix_sum > signed'({3'b0, W_MAX})) begin
			mix_w = W_MAX;
		end else begin
			mix_w = mix_sum[10:0];
		end

		unique case (dec.mode)
			MODE_ZERO:   width = '0;
			MODE_IDLE:   width = 16'(W_MIN);
			MODE_DIRECT: width = direct;
			MODE_MIX:    width = 16'(mix_w);
			default:     width = '0;
		endcase

		// 48 + d*1999/1000 truncated equals 2d + 47 for d in 1..1000
		w_clamped = (width > 16'(W_MAX)) ? W_MAX : width[10:0];
		above_min = 10'(w_clamped - W_MIN);
		if (width <= 16'(W_MIN)) begin
			dshot = '0;
		end else begin
			dshot = {above_min, 1'b0} + DS_OFFSET;
		end
	end

endmodule

>>> hdl/quad_motor_output_selector_top.sv
// quad motor output selector: arming and source control, four motor lanes,
// merged result register. updates pass the decision and result registers,
// one per cycle unless output stalls; control state moves at the input transfer.
// arst_n clears arming state, pid cache, valids; config takes its reset values.
// depends on qmos_pkg, qmos_in_if, qmos_out_if, qmos_ctrl, qmos_lane

module quad_motor_output_selector_top
	import qmos_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	qmos_in_if.sink     in_ch,
	qmos_out_if.source  out_ch,
	input  logic        cfg_we,
	input  cfg_idx_t    cfg_index,
	input  logic [15:0] cfg_data
);

	logic      valid_s1;
	logic      valid_s2;
	logic      adv_s1;
	logic      adv_s2;
	logic      accept;
	decision_t dec_s1;

	logic [MOTOR_COUNT-1:0][15:0] pid_widths;
	logic [MOTOR_COUNT-1:0][15:0] lane_width;
	logic [MOTOR_COUNT-1:0][10:0] lane_dshot;
	logic [MOTOR_COUNT-1:0][15:0] width_s2;
	logic [MOTOR_COUNT-1:0][10:0] dshot_s2;
	logic send_s2;
	logic report_s2;
	logic from_pid_s2;
	logic esc_s2;

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign in_ch.ready = adv_s1;
	assign accept      = in_ch.valid && adv_s1;

	assign pid_widths = {in_ch.pid_rear_left, in_ch.pid_rear_right,
	                     in_ch.pid_front_right, in_ch.pid_front_left};

	qmos_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.now_ms      (in_ch.now_ms),
		.rc_armed    (in_ch.rc_armed),
		.rc_throttle (in_ch.rc_throttle),
		.rc_roll     (in_ch.rc_roll),
		.rc_pitch    (in_ch.rc_pitch),
		.rc_yaw      (in_ch.rc_yaw),
		.pid_fresh   (in_ch.pid_fresh),
		.pid_widths  (pid_widths),
		.dec_s1      (dec_s1)
	);

	for (genvar i = 0; i < MOTOR_COUNT; i++) begin : g_lane
		qmos_lane #(.SIGNS(MIX_SIGNS[i])) u_lane (
			.dec    (dec_s1),
			.direct (dec_s1.direct[i]),
			.width  (lane_width[i]),
			.dshot  (lane_dshot[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// merge lane results with the frame flags
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			width_s2    <= lane_width;
			dshot_s2    <= lane_dshot;
			send_s2     <= dec_s1.send_valid;
			report_s2   <= dec_s1.report_valid;
			from_pid_s2 <= dec_s1.from_pid;
			esc_s2      <= dec_s1.esc_is_armed;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.send_valid   = send_s2;
	assign out_ch.report_valid = report_s2;
	assign out_ch.from_pid     = from_pid_s2;
	assign out_ch.esc_is_armed = esc_s2;
	assign out_ch.dshot_one    = dshot_s2[0];
	assign out_ch.dshot_two    = dshot_s2[1];
	assign out_ch.dshot_three  = dshot_s2[2];
	assign out_ch.dshot_four   = dshot_s2[3];
	assign out_ch.width_one    = width_s2[0];
	assign out_ch.width_two    = width_s2[1];
	assign out_ch.width_three  = width_s2[2];
	assign out_ch.width_four   = width_s2[3];

	// no telemetry report means the arming zero frame
	a_arming_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.report_valid |->
			out_ch.send_valid && out_ch.dshot_one == 11'd0 && out_ch.dshot_four == 11'd0 &&
			out_ch.width_one == 16'd0 && !out_ch.esc_is_armed)
		else $error("arming frame carries nonzero throttle");

	// an unarmed esc never gets a nonzero throttle
	a_unarmed_no_throttle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.esc_is_armed |->
			out_ch.dshot_one == 11'd0 && out_ch.dshot_two == 11'd0 &&
			out_ch.dshot_three == 11'd0 && out_ch.dshot_four == 11'd0)
		else $error("throttle sent to unarmed esc");

	// dshot values below 48 are commands, never throttle
	a_dshot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
			(out_ch.dshot_one == 11'd0 || out_ch.dshot_one >= 11'd48) &&
			(out_ch.dshot_three == 11'd0 || out_ch.dshot_three >= 11'd48))
		else $error("dshot value in command range");

endmodule
